/* src/qrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

	// Coefficient and root format.
	localparam int COEF_WIDTH = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_THR_WIDTH = 16;
	localparam int DISC_THR_WIDTH = 32;
	localparam int CFG_DATA_WIDTH = 32;

	// Result classification.
	typedef enum logic [1:0] {
		ST_NOT_QUAD = 2'd0,
		ST_NO_REAL  = 2'd1,
		ST_DOUBLE   = 2'd2,
		ST_TWO      = 2'd3
	} root_status_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_COEF_THR = 1'b0,
		REG_DISC_THR = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] coef_a;
		logic signed [COEF_WIDTH-1:0] coef_b;
		logic signed [COEF_WIDTH-1:0] coef_c;
	} in_t;

	typedef struct packed {
		root_status_t                 root_status;
		logic signed [COEF_WIDTH-1:0] root_minus;
		logic signed [COEF_WIDTH-1:0] root_plus;
		logic                         root_overflow;
	} out_t;

endpackage

`default_nettype wire

/* src/qrs_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One digit of the square root: brings down two radicand bits and decides
// one root bit, then registers the partial result for the next cell.
module qrs_sqrt_cell #(
	parameter int DW  = 66,
	parameter int RTW = 33,
	parameter int RMW = 35,
	parameter int SBW = 67
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           vld_i,
	input  wire logic [DW-1:0]  dsh_i,
	input  wire logic [RTW-1:0] root_i,
	input  wire logic [RMW-1:0] rem_i,
	input  wire logic [SBW-1:0] sb_i,
	output logic                vld_o,
	output logic [DW-1:0]       dsh_o,
	output logic [RTW-1:0]      root_o,
	output logic [RMW-1:0]      rem_o,
	output logic [SBW-1:0]      sb_o
);

	logic [RMW+1:0] sh;
	logic [RMW+1:0] trial;
	logic           ge;

	// Trial subtraction of 4*root+1.
	always_comb begin
		sh    = {rem_i, dsh_i[DW-1 -: 2]};
		trial = (RMW+2)'({root_i, 2'b01});
		ge    = (sh >= trial);
	end

	// Control bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_i;
		end
	end

	// Partial root and remainder.
	always_ff @(posedge clk) begin
		if (adv) begin
			dsh_o  <= dsh_i << 2;
			root_o <= {root_i[RTW-2:0], ge};
			rem_o  <= ge ? RMW'(sh - trial) : RMW'(sh);
			sb_o   <= sb_i;
		end
	end

endmodule

`default_nettype wire

/* src/qrs_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step for both root lanes sharing the divisor.
module qrs_div_cell #(
	parameter int NW  = 50,
	parameter int DNW = 33,
	parameter int SBW = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           vld_i,
	input  wire logic [DNW-1:0] den_i,
	input  wire logic [NW-1:0]  num_m_i,
	input  wire logic [NW-1:0]  num_p_i,
	input  wire logic [DNW-1:0] rem_m_i,
	input  wire logic [DNW-1:0] rem_p_i,
	input  wire logic [NW-1:0]  q_m_i,
	input  wire logic [NW-1:0]  q_p_i,
	input  wire logic [SBW-1:0] sb_i,
	output logic                vld_o,
	output logic [DNW-1:0]      den_o,
	output logic [NW-1:0]       num_m_o,
	output logic [NW-1:0]       num_p_o,
	output logic [DNW-1:0]      rem_m_o,
	output logic [DNW-1:0]      rem_p_o,
	output logic [NW-1:0]       q_m_o,
	output logic [NW-1:0]       q_p_o,
	output logic [SBW-1:0]      sb_o
);

	logic [DNW:0] sh_m;
	logic [DNW:0] sh_p;
	logic         ge_m;
	logic         ge_p;

	// Shift in the next numerator bit and compare against the divisor.
	always_comb begin
		sh_m = {rem_m_i, num_m_i[NW-1]};
		sh_p = {rem_p_i, num_p_i[NW-1]};
		ge_m = (sh_m >= {1'b0, den_i});
		ge_p = (sh_p >= {1'b0, den_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_i;
		end
	end

	// Remainders and quotient bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			den_o   <= den_i;
			num_m_o <= num_m_i << 1;
			num_p_o <= num_p_i << 1;
			rem_m_o <= ge_m ? DNW'(sh_m - {1'b0, den_i}) : DNW'(sh_m);
			rem_p_o <= ge_p ? DNW'(sh_p - {1'b0, den_i}) : DNW'(sh_p);
			q_m_o   <= {q_m_i[NW-2:0], ge_m};
			q_p_o   <= {q_p_i[NW-2:0], ge_p};
			sb_o    <= sb_i;
		end
	end

endmodule

`default_nettype wire

/* src/quadratic_root_solver.sv */
`timescale 1ns / 1ps
`default_nettype none

// Real roots of a*x^2+b*x+c=0 in signed fixed point. The solver is fully
// pipelined and takes one beat per cycle while in_stall is low. A beat
// passes through 4 + (COEF_WIDTH+1) + 1 + (COEF_WIDTH+2+FRAC_BITS) + 1 register
// stages, with the default format Q16.16. The stage count is set by the square
// root chain of one cell per root bit followed by the divider chain of one cell
// per quotient bit. The whole pipeline advances together; in_stall rises only
// while a finished result waits at the output and out_stall is high. Thresholds
// are written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the pipeline is empty, which the block itself does not enforce.
module quadratic_root_solver #(
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire qrs_pkg::in_t                         in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output qrs_pkg::out_t                             out_data,
	input  wire logic                                 cfg_we,
	input  wire qrs_pkg::cfg_reg_t                    cfg_index,
	input  wire logic [qrs_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	import qrs_pkg::*;

	localparam int W   = COEF_WIDTH;
	localparam int DW  = 2*W + 2;
	localparam int RTW = W + 1;
	localparam int RMW = W + 3;
	localparam int SQN = W + 1;
	localparam int SB1 = 2*W + 3;
	localparam int NSW = W + 3;
	localparam int MW  = W + 2;
	localparam int NW  = MW + FRAC_BITS;
	localparam int DNW = W + 1;
	localparam int SB2 = 4;

	logic adv;
	logic [COEF_THR_WIDTH-1:0] coef_thr_q;
	logic [DISC_THR_WIDTH-1:0] disc_thr_q;

	// Whole pipeline moves when the output register is free or drained.
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_thr_q <= '0;
			disc_thr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_THR: coef_thr_q <= cfg_data[COEF_THR_WIDTH-1:0];
				REG_DISC_THR: disc_thr_q <= cfg_data[DISC_THR_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: magnitudes and signs.
	logic         vld_s1, aneg_s1, cneg_s1, zq_s1;
	logic [W-1:0] amag_s1, bmag_s1, cmag_s1;
	logic [W-1:0] b_s1;
	logic [W-1:0] amag_in;

	assign amag_in = in_data.coef_a[W-1] ? W'(-in_data.coef_a) : in_data.coef_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aneg_s1 <= in_data.coef_a[W-1];
			cneg_s1 <= in_data.coef_c[W-1];
			amag_s1 <= amag_in;
			bmag_s1 <= in_data.coef_b[W-1] ? W'(-in_data.coef_b) : in_data.coef_b;
			cmag_s1 <= in_data.coef_c[W-1] ? W'(-in_data.coef_c) : in_data.coef_c;
			b_s1    <= in_data.coef_b;
			zq_s1   <= (amag_in == '0) || (amag_in < W'(coef_thr_q));
		end
	end

	// Stage 2: b*b and a*c.
	logic           vld_s2, aneg_s2, cneg_s2, zq_s2;
	logic [2*W-1:0] bb_s2, ac_s2;
	logic [W-1:0]   amag_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bb_s2   <= (2*W)'(bmag_s1) * (2*W)'(bmag_s1);
			ac_s2   <= (2*W)'(amag_s1) * (2*W)'(cmag_s1);
			aneg_s2 <= aneg_s1;
			cneg_s2 <= cneg_s1;
			zq_s2   <= zq_s1;
			amag_s2 <= amag_s1;
			b_s2    <= b_s1;
		end
	end

	// Stage 3: discriminant magnitude and sign.
	logic          vld_s3, aneg_s3, zq_s3, dneg_s3;
	logic [DW-1:0] d_s3;
	logic [W-1:0]  amag_s3, b_s3;
	logic [DW-1:0] bbx, ac4;

	assign bbx = DW'(bb_s2);
	assign ac4 = {ac_s2, 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (aneg_s2 != cneg_s2) begin
				d_s3    <= bbx + ac4;
				dneg_s3 <= 1'b0;
			end else if (bbx >= ac4) begin
				d_s3    <= bbx - ac4;
				dneg_s3 <= 1'b0;
			end else begin
				d_s3    <= ac4 - bbx;
				dneg_s3 <= 1'b1;
			end
			aneg_s3 <= aneg_s2;
			zq_s3   <= zq_s2;
			amag_s3 <= amag_s2;
			b_s3    <= b_s2;
		end
	end

	// Stage 4: classification.
	logic          vld_s4;
	root_status_t  st_s4;
	logic [DW-1:0] d_s4;
	logic          aneg_s4;
	logic [W-1:0]  amag_s4, b_s4;
	logic          dsmall;

	assign dsmall = (d_s3[DW-1:2*W] == '0) &&
		((d_s3[2*W-1:0] == '0) || (d_s3[2*W-1:0] < (2*W)'(disc_thr_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zq_s3) begin
				st_s4 <= ST_NOT_QUAD;
			end else if (dsmall) begin
				st_s4 <= ST_DOUBLE;
			end else if (!dneg_s3) begin
				st_s4 <= ST_TWO;
			end else begin
				st_s4 <= ST_NO_REAL;
			end
			d_s4    <= d_s3;
			aneg_s4 <= aneg_s3;
			amag_s4 <= amag_s3;
			b_s4    <= b_s3;
		end
	end

	// Square root chain, one root bit per cell.
	logic           sq_vld  [0:SQN];
	logic [DW-1:0]  sq_dsh  [0:SQN];
	logic [RTW-1:0] sq_root [0:SQN];
	logic [RMW-1:0] sq_rem  [0:SQN];
	logic [SB1-1:0] sq_sb   [0:SQN];

	assign sq_vld[0]  = vld_s4;
	assign sq_dsh[0]  = d_s4;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;
	assign sq_sb[0]   = {st_s4, aneg_s4, amag_s4, b_s4};

	for (genvar i = 0; i < SQN; i++) begin : g_sqrt
		qrs_sqrt_cell #(
			.DW (DW),
			.RTW(RTW),
			.RMW(RMW),
			.SBW(SB1)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_i (sq_vld[i]),
			.dsh_i (sq_dsh[i]),
			.root_i(sq_root[i]),
			.rem_i (sq_rem[i]),
			.sb_i  (sq_sb[i]),
			.vld_o (sq_vld[i+1]),
			.dsh_o (sq_dsh[i+1]),
			.root_o(sq_root[i+1]),
			.rem_o (sq_rem[i+1]),
			.sb_o  (sq_sb[i+1])
		);
	end

	// Stage 5: numerators -b -/+ sqrt(D), split into sign and magnitude.
	root_status_t   sq_st;
	logic           sq_aneg;
	logic [W-1:0]   sq_amag, sq_b;
	logic [NSW-1:0] nb, sroot, nm, np;

	assign {sq_st, sq_aneg, sq_amag, sq_b} = sq_sb[SQN];
	assign nb    = -NSW'(signed'(sq_b));
	assign sroot = (sq_st == ST_TWO) ? NSW'(sq_root[SQN]) : '0;
	assign nm    = nb - sroot;
	assign np    = nb + sroot;

	logic          vld_s5;
	root_status_t  st_s5;
	logic          rneg_m_s5, rneg_p_s5;
	logic [MW-1:0] mm_s5, mp_s5;
	logic [DNW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= sq_vld[SQN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s5     <= sq_st;
			rneg_m_s5 <= nm[NSW-1] != sq_aneg;
			rneg_p_s5 <= np[NSW-1] != sq_aneg;
			mm_s5     <= MW'(nm[NSW-1] ? -nm : nm);
			mp_s5     <= MW'(np[NSW-1] ? -np : np);
			den_s5    <= {sq_amag, 1'b0};
		end
	end

	// Divider chain, one quotient bit per cell for both roots.
	logic           dv_vld [0:NW];
	logic [DNW-1:0] dv_den [0:NW];
	logic [NW-1:0]  dv_nm  [0:NW];
	logic [NW-1:0]  dv_np  [0:NW];
	logic [DNW-1:0] dv_rm  [0:NW];
	logic [DNW-1:0] dv_rp  [0:NW];
	logic [NW-1:0]  dv_qm  [0:NW];
	logic [NW-1:0]  dv_qp  [0:NW];
	logic [SB2-1:0] dv_sb  [0:NW];

	assign dv_vld[0] = vld_s5;
	assign dv_den[0] = den_s5;
	assign dv_nm[0]  = NW'(mm_s5) << FRAC_BITS;
	assign dv_np[0]  = NW'(mp_s5) << FRAC_BITS;
	assign dv_rm[0]  = '0;
	assign dv_rp[0]  = '0;
	assign dv_qm[0]  = '0;
	assign dv_qp[0]  = '0;
	assign dv_sb[0]  = {st_s5, rneg_m_s5, rneg_p_s5};

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(
			.NW (NW),
			.DNW(DNW),
			.SBW(SB2)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (dv_vld[j]),
			.den_i  (dv_den[j]),
			.num_m_i(dv_nm[j]),
			.num_p_i(dv_np[j]),
			.rem_m_i(dv_rm[j]),
			.rem_p_i(dv_rp[j]),
			.q_m_i  (dv_qm[j]),
			.q_p_i  (dv_qp[j]),
			.sb_i   (dv_sb[j]),
			.vld_o  (dv_vld[j+1]),
			.den_o  (dv_den[j+1]),
			.num_m_o(dv_nm[j+1]),
			.num_p_o(dv_np[j+1]),
			.rem_m_o(dv_rm[j+1]),
			.rem_p_o(dv_rp[j+1]),
			.q_m_o  (dv_qm[j+1]),
			.q_p_o  (dv_qp[j+1]),
			.sb_o   (dv_sb[j+1])
		);
	end

	// Saturation, sign and masking into the output register.
	root_status_t dv_st;
	logic         dv_rneg_m, dv_rneg_p;
	logic [NW-1:0] lim_m, lim_p;
	logic         sat_m, sat_p, has_roots;
	logic [W-1:0] qm_w, qp_w;

	assign {dv_st, dv_rneg_m, dv_rneg_p} = dv_sb[NW];
	assign lim_m = dv_rneg_m ? NW'({1'b1, {(W-1){1'b0}}}) : NW'({1'b0, {(W-1){1'b1}}});
	assign lim_p = dv_rneg_p ? NW'({1'b1, {(W-1){1'b0}}}) : NW'({1'b0, {(W-1){1'b1}}});
	assign sat_m = dv_qm[NW] > lim_m;
	assign sat_p = dv_qp[NW] > lim_p;
	assign qm_w  = sat_m ? lim_m[W-1:0] : dv_qm[NW][W-1:0];
	assign qp_w  = sat_p ? lim_p[W-1:0] : dv_qp[NW][W-1:0];
	assign has_roots = (dv_st == ST_DOUBLE) || (dv_st == ST_TWO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.root_status   <= dv_st;
			out_data.root_minus    <= has_roots ? (dv_rneg_m ? -qm_w : qm_w) : '0;
			out_data.root_plus     <= has_roots ? (dv_rneg_p ? -qp_w : qp_w) : '0;
			out_data.root_overflow <= has_roots && (sat_m || sat_p);
		end
	end

`ifndef NO_ASSERTIONS
	// Input side stalls only because a result is held at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// Without real roots both root fields and the flag are zero.
	a_no_roots_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((out_data.root_status == ST_NOT_QUAD) ||
		(out_data.root_status == ST_NO_REAL))) |->
		(out_data.root_minus == '0 && out_data.root_plus == '0 && !out_data.root_overflow))
		else $error("roots reported for an equation without real roots");

	// A double root gives the same value on both fields.
	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.root_status == ST_DOUBLE) |->
		(out_data.root_minus == out_data.root_plus))
		else $error("double root fields differ");

	// A held result stays put while the pipeline is frozen.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(out_data) && out_valid))
		else $error("held result changed");
`endif

endmodule

`default_nettype wire
